>>> rtl/assert_macros.svh
// Assertion macros shared by the input event report queue RTL.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define IERQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that an expression is never true outside reset.
`define IERQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IERQ_ASSERT(label, clk, rst, prop, msg)
`define IERQ_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> rtl/ierq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and pointer helpers of the input event report queue.
// Depends on nothing.
package ierq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int EV_W        = 64;
   localparam int TIME_W      = 64;
   localparam int CNT_W       = 6;
   localparam int CNT_MAX     = 63;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // Event type and code values with a special meaning.
   localparam logic [15:0] EV_SYN       = 16'd0;
   localparam logic [15:0] CODE_REPORT  = 16'd0;
   localparam logic [15:0] CODE_DROPPED = 16'd3;

   // Command codes.
   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_FILTER = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
      logic [63:0]        now_time;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_type;
      logic [15:0]        out_code;
      logic signed [31:0] out_value;
      logic [63:0]        out_time;
      logic               event_valid;
      logic               overflowed;
      logic [CNT_W-1:0]   ready_count;
   } rsp_type;

   // Write and read requests from the sequencer to the two entry memories.
   typedef struct packed {
      logic              ev_we;
      logic [PTR_W-1:0]  ev_waddr;
      logic [EV_W-1:0]   ev_wdata;
      logic              tm_we;
      logic [PTR_W-1:0]  tm_waddr;
      logic [TIME_W-1:0] tm_wdata;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
   } mem_req_type;

   // Next slot of the ring, wrapping at the depth.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // Previous slot of the ring, wrapping at zero.
   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   // Committed entries between head and ready, saturated to the count width.
   function automatic logic [CNT_W-1:0] ready_count_of(input logic [PTR_W-1:0] head,
                                                        input logic [PTR_W-1:0] ready);
      logic [PTR_W:0] diff;
      if (ready >= head) begin
         diff = {1'b0, ready} - {1'b0, head};
      end else begin
         diff = {1'b0, ready} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, head};
      end
      if (32'(diff) > 32'(CNT_MAX)) begin
         return CNT_W'(CNT_MAX);
      end
      return CNT_W'(diff);
   endfunction

endpackage

>>> rtl/ierq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module ierq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered and updates only when rd_en is set.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ierq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the event queue: ring pointers, push, report stamping, pop and filter.
// Depends on ierq_pkg and assert_macros.svh; drives the two entry memories.
`include "assert_macros.svh"
module ierq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ierq_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ierq_pkg::rsp_type     rsp_payload,
   output ierq_pkg::mem_req_type mem,
   input  logic [ierq_pkg::EV_W-1:0]   ev_rdata,
   input  logic [ierq_pkg::TIME_W-1:0] tm_rdata
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_PUSH_DROP = 3'd1;
   localparam logic [2:0] S_PUSH_EV   = 3'd2;
   localparam logic [2:0] S_STAMP     = 3'd3;
   localparam logic [2:0] S_POP_RD    = 3'd4;
   localparam logic [2:0] S_FILT      = 3'd5;
   localparam logic [2:0] S_FIN       = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [ierq_pkg::PTR_W-1:0] head_ff, head_in;
   logic [ierq_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [ierq_pkg::PTR_W-1:0] ready_ff, ready_in;
   logic [ierq_pkg::PTR_W-1:0] rd_ff, rd_in;
   logic [ierq_pkg::PTR_W-1:0] wr_ff, wr_in;
   logic [ierq_pkg::PTR_W-1:0] stamp_ff, stamp_in;
   logic prev_rep_ff, prev_rep_in;
   logic rsp_valid_ff, rsp_valid_in;
   ierq_pkg::req_type req_ff, req_in;
   ierq_pkg::rsp_type res_ff, res_in;
   ierq_pkg::rsp_type rsp_ff, rsp_in;

   logic full;
   logic rd_rep;
   logic rd_keep;

   assign full = (ierq_pkg::ptr_next(tail_ff) == head_ff);

   // Classification of the entry read back during a filter pass.
   assign rd_rep  = (ev_rdata[63:48] == ierq_pkg::EV_SYN) &&
                    (ev_rdata[47:32] == ierq_pkg::CODE_REPORT);
   assign rd_keep = (ev_rdata[63:48] != req_ff.event_type) && !(rd_rep && prev_rep_ff);

   // Next-state logic of the sequencer and the memory requests.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ready_in     = ready_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      stamp_in     = stamp_ff;
      prev_rep_in  = prev_rep_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem          = '0;
      mem.rd_addr  = head_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               res_in = '0;
               case (req_payload.cmd)
                  ierq_pkg::CMD_PUSH: begin
                     res_in.overflowed = full;
                     state_in = full ? S_PUSH_DROP : S_PUSH_EV;
                  end
                  ierq_pkg::CMD_POP: begin
                     if (head_ff != ready_ff) begin
                        mem.rd_en = 1'b1;
                        state_in  = S_POP_RD;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  ierq_pkg::CMD_FILTER: begin
                     ready_in    = tail_ff;
                     wr_in       = tail_ff;
                     prev_rep_in = 1'b0;
                     if (head_ff != tail_ff) begin
                        mem.rd_en = 1'b1;
                        rd_in     = ierq_pkg::ptr_next(head_ff);
                        state_in  = S_FILT;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         // Full ring: collapse to a dropped marker just before the tail.
         S_PUSH_DROP: begin
            mem.ev_we    = 1'b1;
            mem.ev_waddr = ierq_pkg::ptr_prev(tail_ff);
            mem.ev_wdata = {ierq_pkg::EV_SYN, ierq_pkg::CODE_DROPPED, 32'd0};
            head_in      = ierq_pkg::ptr_prev(tail_ff);
            ready_in     = ierq_pkg::ptr_prev(tail_ff);
            state_in     = S_PUSH_EV;
         end

         // Write the new event at the tail; a report then stamps and commits.
         S_PUSH_EV: begin
            mem.ev_we    = 1'b1;
            mem.ev_waddr = tail_ff;
            mem.ev_wdata = {req_ff.event_type, req_ff.event_code, req_ff.event_value};
            tail_in      = ierq_pkg::ptr_next(tail_ff);
            if ((req_ff.event_type == ierq_pkg::EV_SYN) &&
                (req_ff.event_code == ierq_pkg::CODE_REPORT)) begin
               stamp_in = ready_ff;
               state_in = S_STAMP;
            end else begin
               state_in = S_FIN;
            end
         end

         // Stamp one uncommitted entry per cycle, then commit up to the tail.
         S_STAMP: begin
            mem.tm_we    = 1'b1;
            mem.tm_waddr = stamp_ff;
            mem.tm_wdata = req_ff.now_time;
            stamp_in     = ierq_pkg::ptr_next(stamp_ff);
            if (ierq_pkg::ptr_next(stamp_ff) == tail_ff) begin
               ready_in = tail_ff;
               state_in = S_FIN;
            end
         end

         // Head entry is back from both memories.
         S_POP_RD: begin
            res_in.out_type    = ev_rdata[63:48];
            res_in.out_code    = ev_rdata[47:32];
            res_in.out_value   = signed'(ev_rdata[31:0]);
            res_in.out_time    = tm_rdata;
            res_in.event_valid = 1'b1;
            head_in            = ierq_pkg::ptr_next(head_ff);
            state_in           = S_FIN;
         end

         // Compaction: read the next entry while the previous one is copied
         // to the write pointer past the old tail.
         S_FILT: begin
            if (rd_ff != tail_ff) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = rd_ff;
               rd_in       = ierq_pkg::ptr_next(rd_ff);
            end
            if (rd_keep) begin
               mem.ev_we    = 1'b1;
               mem.ev_waddr = wr_ff;
               mem.ev_wdata = ev_rdata;
               mem.tm_we    = 1'b1;
               mem.tm_waddr = wr_ff;
               mem.tm_wdata = tm_rdata;
               wr_in        = ierq_pkg::ptr_next(wr_ff);
               prev_rep_in  = rd_rep;
               if (rd_rep) begin
                  ready_in = ierq_pkg::ptr_next(wr_ff);
               end
            end
            if (rd_ff == tail_ff) begin
               head_in  = rd_ff;
               tail_in  = rd_keep ? ierq_pkg::ptr_next(wr_ff) : wr_ff;
               state_in = S_FIN;
            end
         end

         // Hand the result to the output register once it is free.
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in             = res_ff;
               rsp_in.ready_count = ierq_pkg::ready_count_of(head_ff, ready_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         ready_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      stamp_ff    <= stamp_in;
      prev_rep_ff <= prev_rep_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The memories are only written while an operation is in progress.
   `IERQ_NEVER(a_no_write_idle, clock, reset, (state_ff == S_IDLE || state_ff == S_FIN) && (mem.ev_we || mem.tm_we), "memory write outside an operation")
   // Compaction never overwrites the entry that is being read.
   `IERQ_NEVER(a_filt_no_clash, clock, reset, mem.ev_we && mem.rd_en && (mem.ev_waddr == mem.rd_addr), "filter write hits the read address")
   // A new result only appears after the finishing state.
   `IERQ_ASSERT(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN, "result raised outside the finishing state")
   // A report commit leaves ready at the tail.
   `IERQ_ASSERT(a_stamp_commit, clock, reset, (state_ff == S_STAMP && state_in == S_FIN) |=> ready_ff == tail_ff, "report commit did not reach the tail")

endmodule

>>> rtl/input_event_report_queue.sv
`timescale 1ns / 1ps
// Input event report queue: a ring of input events with head, commit and tail pointers.
// Push writes the event at the tail, on a full ring after a dropped marker just before the
// tail; a report then stamps each uncommitted entry. Pop returns the head entry, or no event
// when nothing is committed; a no-op only returns a result; filter compacts the stored entries.
// One transaction at a time: the next can be accepted in the same cycle as its result appears.
// Reset clears the pointers only, not the entry memories. Uses ierq_pkg, ierq_ram, ierq_ctrl.
module input_event_report_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ierq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ierq_pkg::rsp_type rsp_payload
);

   ierq_pkg::mem_req_type mem;
   logic [ierq_pkg::EV_W-1:0]   ev_rdata;
   logic [ierq_pkg::TIME_W-1:0] tm_rdata;

   // Event words: type, code and value.
   ierq_ram #(
      .DEPTH (ierq_pkg::QUEUE_DEPTH),
      .WIDTH (ierq_pkg::EV_W)
   ) u_event_store (
      .clock   (clock),
      .wr_en   (mem.ev_we),
      .wr_addr (mem.ev_waddr),
      .wr_data (mem.ev_wdata),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (ev_rdata)
   );

   // Timestamps stamped at report commit.
   ierq_ram #(
      .DEPTH (ierq_pkg::QUEUE_DEPTH),
      .WIDTH (ierq_pkg::TIME_W)
   ) u_time_store (
      .clock   (clock),
      .wr_en   (mem.tm_we),
      .wr_addr (mem.tm_waddr),
      .wr_data (mem.tm_wdata),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (tm_rdata)
   );

   // Pointer sequencer and result register.
   ierq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem         (mem),
      .ev_rdata    (ev_rdata),
      .tm_rdata    (tm_rdata)
   );

endmodule
